@@ hdl/tlba_pkg.sv @@
// ----------------------------------------------------------------------------
// tlba_pkg
// Shared field widths and action codes of the bitmap index allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tlba_pkg;

  localparam int ACTION_W    = 3;
  localparam int INDEX_IN_W  = 12;
  localparam int INDEX_OUT_W = 13;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC    = 3'd0,
    ACT_FREE     = 3'd1,
    ACT_CONTAINS = 3'd2,
    ACT_FIRST    = 3'd3,
    ACT_NEXT     = 3'd4,
    ACT_CLEAR    = 3'd5
  } action_t;

endpackage

`default_nettype wire

@@ hdl/tlba_if.sv @@
// ----------------------------------------------------------------------------
// tlba_if
// Request and result channels of the bitmap index allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlba_in_if;
  logic                              valid;
  logic                              ready;
  logic [tlba_pkg::ACTION_W-1:0]     action;
  logic [tlba_pkg::INDEX_IN_W-1:0]   index_in;

  modport source (output valid, output action, output index_in, input ready);
  modport sink   (input valid, input action, input index_in, output ready);
endinterface

interface tlba_out_if;
  logic                              valid;
  logic                              ready;
  logic [tlba_pkg::INDEX_OUT_W-1:0]  index_out;
  logic                              ok;
  logic [tlba_pkg::INDEX_OUT_W-1:0]  live_count;

  modport source (output valid, output index_out, output ok, output live_count,
                  input ready);
  modport sink   (input valid, input index_out, input ok, input live_count,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/two_level_bitmap_index_allocator_core.sv @@
// ----------------------------------------------------------------------------
// two_level_bitmap_index_allocator_core
// Two-level bitmap allocator: lower words in a synchronous memory, full marks
// and word valid bits in flops, one result word per request word.
// ----------------------------------------------------------------------------
// Sequence: an accepted request passes S_ADDR, S_EXEC and S_DONE into the result
//   word; clear all, allocate when full, indexes out of range (next after the
//   last index) and undefined actions skip S_EXEC. Each further word scanned is
//   one more S_EXEC pass (up to WORD_COUNT-1), set by the one read port.
// Flow: one request in flight, the next taken after S_DONE, later while a
//   result word waits. Reset and clear all drop marks, valid bits, count.
`default_nettype none

module two_level_bitmap_index_allocator_core #(
  parameter int WORD_BITS  = 64,
  parameter int WORD_COUNT = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tlba_in_if.sink     in_ch,
  tlba_out_if.source  out_ch
);

  localparam int OW     = tlba_pkg::INDEX_OUT_W;
  localparam int SCAN_W = 64;
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int WI_W   = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int SHIFT  = OW + BIT_W;
  localparam int M_W    = OW + 2;
  localparam int PROD_W = OW + M_W;
  localparam logic [M_W-1:0] RECIP =
    M_W'(((64'd1 << SHIFT) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
  localparam logic [OW-1:0]   CAP    = OW'(WORD_BITS * WORD_COUNT);
  localparam logic [OW-1:0]   WB_OW  = OW'(WORD_BITS);
  localparam logic [WI_W-1:0] LAST_W = WI_W'(WORD_COUNT - 1);
  localparam logic [WORD_BITS-1:0] ONE_W = {{(WORD_BITS-1){1'b0}}, 1'b1};

  typedef enum logic [1:0] {S_IDLE, S_ADDR, S_EXEC, S_DONE} state_t;

  function automatic logic [5:0] lsb_pos(input logic [SCAN_W-1:0] w);
    logic [SCAN_W-1:0] iso;
    logic [5:0]        p;
    iso = w & (~w + 64'd1);
    p   = '0;
    for (int i = 0; i < SCAN_W; i++) begin
      if (iso[i]) p = p | 6'(i);
    end
    return p;
  endfunction

  state_t                     state_r, state_nxt;
  tlba_pkg::action_t          action_r, action_nxt;
  logic [OW-1:0]              pos_r, pos_nxt;
  logic                       in_rng_r, in_rng_nxt;
  logic [WI_W-1:0]            q_r, q_nxt;
  logic [WI_W-1:0]            wi_r, wi_nxt;
  logic [OW-1:0]              base_r, base_nxt;
  logic [BIT_W-1:0]           bit_r, bit_nxt;
  logic [WORD_COUNT-1:0]      marks_r, marks_nxt;
  logic [WORD_COUNT-1:0]      valid_r, valid_nxt;
  logic [OW-1:0]              count_r, count_nxt;
  logic [OW-1:0]              res_idx_r, res_idx_nxt;
  logic                       res_ok_r, res_ok_nxt;
  logic [OW-1:0]              res_cnt_r, res_cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [OW-1:0]              out_idx_r, out_idx_nxt;
  logic                       out_ok_r, out_ok_nxt;
  logic [OW-1:0]              out_cnt_r, out_cnt_nxt;

  logic [WORD_BITS-1:0]       mem [WORD_COUNT];
  logic [WORD_BITS-1:0]       rd_data_r;
  logic                       rd_vld_r;
  logic                       rd_en;
  logic [WI_W-1:0]            rd_addr;
  logic                       wr_en;
  logic [WORD_BITS-1:0]       wr_data;

  tlba_pkg::action_t          in_action;
  logic [OW-1:0]              in_pos;
  logic [PROD_W-1:0]          prod;
  logic [WORD_COUNT-1:0]      not_full;
  logic [WI_W-1:0]            alloc_wi;
  logic [WI_W-1:0]            word_sel;
  logic [OW-1:0]              sel_base;
  logic [WORD_BITS-1:0]       word;
  logic [WORD_BITS-1:0]       inv;
  logic [WORD_BITS-1:0]       set_word;
  logic [WORD_BITS-1:0]       bm;
  logic [WORD_BITS-1:0]       hi;
  logic [BIT_W-1:0]           free_b;
  logic [BIT_W-1:0]           hit_b;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.index_out = out_idx_r;
  assign out_ch.ok        = out_ok_r;
  assign out_ch.live_count = out_cnt_r;

  assign in_action = tlba_pkg::action_t'(in_ch.action);
  assign in_pos    = (in_action == tlba_pkg::ACT_NEXT)  ? OW'(in_ch.index_in) + OW'(1) :
                     (in_action == tlba_pkg::ACT_FIRST) ? '0 : OW'(in_ch.index_in);
  assign prod      = PROD_W'(in_pos) * PROD_W'(RECIP);

  assign not_full  = ~marks_r;
  assign alloc_wi  = WI_W'(lsb_pos(SCAN_W'(not_full)));
  assign word_sel  = (action_r == tlba_pkg::ACT_ALLOC) ? alloc_wi : q_r;
  assign sel_base  = OW'(word_sel) * WB_OW;

  assign word      = rd_vld_r ? rd_data_r : '0;
  assign inv       = ~word;
  assign free_b    = BIT_W'(lsb_pos(SCAN_W'(inv)));
  assign set_word  = word | (ONE_W << free_b);
  assign bm        = ONE_W << bit_r;
  assign hi        = word & ~(bm - ONE_W);
  assign hit_b     = BIT_W'(lsb_pos(SCAN_W'(hi)));

  always_comb begin
    state_nxt     = state_r;
    action_nxt    = action_r;
    pos_nxt       = pos_r;
    in_rng_nxt    = in_rng_r;
    q_nxt         = q_r;
    wi_nxt        = wi_r;
    base_nxt      = base_r;
    bit_nxt       = bit_r;
    marks_nxt     = marks_r;
    valid_nxt     = valid_r;
    count_nxt     = count_r;
    res_idx_nxt   = res_idx_r;
    res_ok_nxt    = res_ok_r;
    res_cnt_nxt   = res_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_idx_nxt   = out_idx_r;
    out_ok_nxt    = out_ok_r;
    out_cnt_nxt   = out_cnt_r;
    rd_en         = 1'b0;
    rd_addr       = word_sel;
    wr_en         = 1'b0;
    wr_data       = set_word;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          action_nxt = in_action;
          pos_nxt    = in_pos;
          in_rng_nxt = (in_pos < CAP);
          q_nxt      = WI_W'(prod >> SHIFT);
          state_nxt  = S_ADDR;
        end
      end
      S_ADDR: begin
        res_idx_nxt = CAP;
        res_ok_nxt  = 1'b0;
        res_cnt_nxt = count_r;
        state_nxt   = S_DONE;
        wi_nxt      = word_sel;
        base_nxt    = sel_base;
        bit_nxt     = BIT_W'(pos_r - sel_base);
        case (action_r)
          tlba_pkg::ACT_ALLOC: begin
            if (|not_full) begin
              bit_nxt   = '0;
              rd_en     = 1'b1;
              state_nxt = S_EXEC;
            end
          end
          tlba_pkg::ACT_FREE, tlba_pkg::ACT_CONTAINS: begin
            res_idx_nxt = pos_r;
            if (in_rng_r) begin
              rd_en     = 1'b1;
              state_nxt = S_EXEC;
            end
          end
          tlba_pkg::ACT_FIRST, tlba_pkg::ACT_NEXT: begin
            if (in_rng_r) begin
              rd_en     = 1'b1;
              state_nxt = S_EXEC;
            end
          end
          tlba_pkg::ACT_CLEAR: begin
            marks_nxt   = '0;
            valid_nxt   = '0;
            count_nxt   = '0;
            res_ok_nxt  = 1'b1;
            res_cnt_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_EXEC: begin
        state_nxt   = S_DONE;
        res_idx_nxt = CAP;
        res_ok_nxt  = 1'b0;
        case (action_r)
          tlba_pkg::ACT_ALLOC: begin
            if (|inv) begin
              wr_en             = 1'b1;
              wr_data           = set_word;
              valid_nxt[wi_r]   = 1'b1;
              marks_nxt[wi_r]   = &set_word;
              count_nxt         = count_r + OW'(1);
              res_idx_nxt       = base_r + OW'(free_b);
              res_ok_nxt        = 1'b1;
            end
          end
          tlba_pkg::ACT_FREE: begin
            res_idx_nxt = pos_r;
            if (|(word & bm)) begin
              wr_en           = 1'b1;
              wr_data         = word & ~bm;
              valid_nxt[wi_r] = 1'b1;
              marks_nxt[wi_r] = 1'b0;
              count_nxt       = count_r - OW'(1);
              res_ok_nxt      = 1'b1;
            end
          end
          tlba_pkg::ACT_CONTAINS: begin
            res_idx_nxt = pos_r;
            res_ok_nxt  = |(word & bm);
          end
          tlba_pkg::ACT_FIRST, tlba_pkg::ACT_NEXT: begin
            if (|hi) begin
              res_idx_nxt = base_r + OW'(hit_b);
              res_ok_nxt  = 1'b1;
            end else if (wi_r != LAST_W) begin
              wi_nxt    = wi_r + WI_W'(1);
              base_nxt  = base_r + WB_OW;
              bit_nxt   = '0;
              rd_en     = 1'b1;
              rd_addr   = wi_r + WI_W'(1);
              state_nxt = S_EXEC;
            end
          end
          default: begin
          end
        endcase
        res_cnt_nxt = count_nxt;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_ok_nxt    = res_ok_r;
          out_cnt_nxt   = res_cnt_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wi_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= valid_nxt[rd_addr] & valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      marks_r     <= '0;
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      marks_r     <= marks_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    action_r  <= action_nxt;
    pos_r     <= pos_nxt;
    in_rng_r  <= in_rng_nxt;
    q_r       <= q_nxt;
    wi_r      <= wi_nxt;
    base_r    <= base_nxt;
    bit_r     <= bit_nxt;
    res_idx_r <= res_idx_nxt;
    res_ok_r  <= res_ok_nxt;
    res_cnt_r <= res_cnt_nxt;
    out_idx_r <= out_idx_nxt;
    out_ok_r  <= out_ok_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

endmodule

`default_nettype wire
